@@ hw/rtl/sha256bc_pkg.sv @@
// Shared types, constants and round functions of the SHA-256 block compression.
// Depends on nothing; every other file of the block imports it.
package sha256bc_pkg;

  localparam int WordW   = 32;
  localparam int NumMsg  = 16;
  localparam int NumHash = 8;
  localparam int NumRnd  = 64;

  typedef logic [WordW-1:0] word_t;
  typedef logic [5:0]       rnd_idx_t;
  typedef logic [2:0]       hash_idx_t;

  // Sequencer commands towards the schedule and round units
  typedef struct packed {
    logic     load_word;  // shift an input word into the schedule window
    logic     advance;    // shift the window and append the next expanded word
    logic     init;       // load the working variables with the initial hash
    logic     step;       // run one compression round
    rnd_idx_t round;      // index of the round being run
  } seq_ctrl_t;

  localparam word_t InitHash [NumHash] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t v, input int n);
    return (v >> n) | (v << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t v);
    return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t v);
    return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t v);
    return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t v);
    return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

  function automatic word_t round_k(input rnd_idx_t t);
    word_t k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h428a2f98;
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/sha256bc_if.sv @@
// Valid/ready channel interfaces of the SHA-256 block compression.
// Depends on sha256bc_pkg for the word type.
interface sha256bc_msg_if;
  import sha256bc_pkg::*;
  logic  valid;
  logic  ready;
  word_t message_word;
  modport source (output valid, output message_word, input ready);
  modport sink   (input valid, input message_word, output ready);
endinterface

interface sha256bc_dig_if;
  import sha256bc_pkg::*;
  logic      valid;
  logic      ready;
  word_t     digest_word;
  hash_idx_t digest_index;
  logic      last_word;
  modport source (output valid, output digest_word, output digest_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input digest_index, input last_word,
                  output ready);
endinterface

@@ hw/rtl/sha256bc_sched.sv @@
// Message schedule: a sixteen-word sliding window that expands on the fly.
// Depends on sha256bc_pkg.
module sha256bc_sched (
  input  logic                   clk_i,
  input  sha256bc_pkg::seq_ctrl_t ctrl_i,
  input  sha256bc_pkg::word_t    word_i,
  output sha256bc_pkg::word_t    w_o
);
  import sha256bc_pkg::*;

  word_t win_q [NumMsg];
  word_t win_d [NumMsg];
  word_t next_w;

  // W[t+16] from the window that starts at W[t]
  assign next_w = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
  assign w_o    = win_q[0];

  always_comb begin
    for (int i = 0; i < NumMsg - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[NumMsg-1] = ctrl_i.load_word ? word_i : next_w;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_word || ctrl_i.advance) begin
      win_q <= win_d;
    end
  end

endmodule

@@ hw/rtl/sha256bc_round.sv @@
// Compression round unit: eight working variables and one shared round datapath.
// Depends on sha256bc_pkg.
module sha256bc_round (
  input  logic                    clk_i,
  input  sha256bc_pkg::seq_ctrl_t ctrl_i,
  input  sha256bc_pkg::word_t     w_i,
  output sha256bc_pkg::word_t     v_o [sha256bc_pkg::NumHash]
);
  import sha256bc_pkg::*;

  word_t v_q [NumHash];
  word_t t1;
  word_t t2;

  assign t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + round_k(ctrl_i.round) + w_i;
  assign t2 = big_sigma0(v_q[0])
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign v_o = v_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      v_q <= InitHash;
    end else if (ctrl_i.step) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
  end

endmodule

@@ hw/rtl/sha256bc_digest.sv @@
// Digest buffer: adds the initial hash and hands out the eight words in order.
// Depends on sha256bc_pkg.
module sha256bc_digest (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  sha256bc_pkg::word_t   v_i [sha256bc_pkg::NumHash],
  input  logic                  ready_i,
  output logic                  valid_o,
  output sha256bc_pkg::word_t   word_o,
  output sha256bc_pkg::hash_idx_t index_o,
  output logic                  last_o
);
  import sha256bc_pkg::*;

  word_t     hash_q [NumHash];
  logic      valid_q;
  hash_idx_t idx_q;

  assign valid_o = valid_q;
  assign word_o  = hash_q[idx_q];
  assign index_o = idx_q;
  assign last_o  = (idx_q == hash_idx_t'(NumHash - 1));

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < NumHash; i++) begin
        hash_q[i] <= InitHash[i] + v_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && ready_i) begin
      // drop the buffer after the final word
      if (last_o) begin
        valid_q <= 1'b0;
      end
      idx_q <= idx_q + 3'd1;
    end
  end

endmodule

@@ hw/rtl/sha256_block_compression_top.sv @@
// Top level of the SHA-256 single-block compression with its round sequencer.
// Depends on sha256bc_pkg, sha256bc_if, sha256bc_sched, sha256bc_round and sha256bc_digest.

// The block takes one padded 512-bit message block as sixteen 32-bit transactions on msg_i,
// first word most significant, and returns the eight words of its SHA-256 digest on dig_o,
// word 0 first, with last_word set on the eighth. Every block starts from the standard
// initial hash; there is no chaining between blocks. The sixteen words are taken at up to
// one per cycle. After the sixteenth, msg_i stays not ready while one shared round datapath
// runs the sixty-four rounds, a round per cycle, and the schedule window expands one word per
// cycle alongside it, and then until the digest has moved into the output buffer. From
// then on the next block is accepted while the eight digest words drain. If the previous
// digest has not been fully taken, the finished block waits in the working registers until
// the buffer is free.
module sha256_block_compression_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  sha256bc_msg_if.sink           msg_i,
  sha256bc_dig_if.source         dig_o
);
  import sha256bc_pkg::*;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_ROUNDS,
    ST_FINISH
  } seq_state_e;

  seq_state_e state_q, state_d;
  rnd_idx_t   cnt_q, cnt_d;   // word count while collecting, round index while compressing
  seq_ctrl_t  ctrl;
  logic       accept;
  logic       dig_busy;
  logic       dig_load;
  word_t      w;
  word_t      v [NumHash];

  assign msg_i.ready = (state_q == ST_COLLECT);
  assign accept      = msg_i.valid && msg_i.ready;
  assign dig_busy    = dig_o.valid;

  // Sequencer: collect sixteen words, run sixty-four rounds, then hand over the digest
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    ctrl.load_word = 1'b0;
    ctrl.advance   = 1'b0;
    ctrl.init      = 1'b0;
    ctrl.step      = 1'b0;
    ctrl.round     = cnt_q;
    dig_load       = 1'b0;
    case (state_q)
      ST_COLLECT: begin
        if (accept) begin
          ctrl.load_word = 1'b1;
          if (cnt_q == rnd_idx_t'(NumMsg - 1)) begin
            // last word of the block: prime the working variables
            ctrl.init = 1'b1;
            cnt_d     = '0;
            state_d   = ST_ROUNDS;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
      end
      ST_ROUNDS: begin
        ctrl.step    = 1'b1;
        ctrl.advance = 1'b1;
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == rnd_idx_t'(NumRnd - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold the result until the previous digest has gone out
        if (!dig_busy) begin
          dig_load = 1'b1;
          state_d  = ST_COLLECT;
        end
      end
      default: begin
        state_d = ST_COLLECT;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  sha256bc_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .word_i (msg_i.message_word),
    .w_o    (w)
  );

  sha256bc_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .w_i    (w),
    .v_o    (v)
  );

  sha256bc_digest u_digest (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (dig_load),
    .v_i     (v),
    .ready_i (dig_o.ready),
    .valid_o (dig_o.valid),
    .word_o  (dig_o.digest_word),
    .index_o (dig_o.digest_index),
    .last_o  (dig_o.last_word)
  );

endmodule

@@ tb/sv/tb_sha256_block_compression_top.sv @@
// Self-checking testbench of sha256_block_compression_top: message words in, digest words out.
// Depends on sha256bc_pkg, the sha256bc_msg_if/sha256bc_dig_if interfaces and the block's RTL.
// A table of directed words runs first, then random blocks checked against an own digest model.
`timescale 1ns / 1ps

module tb_sha256_block_compression_top;
  import sha256bc_pkg::*;

  // Stop after about this many message words, rounded up to a whole block.
  localparam int ItemsTarget = 330;
  // Cycles without any transaction on either channel before the run is abandoned.
  localparam int IdleLimit   = 2000;
  // Quiet cycles after the last digest word, to catch stray results.
  localparam int DrainCycles = 100;
  localparam int DirRows     = 25;

  // One row of the directed table: the word, and whether this row closes the known block.
  typedef struct packed {
    logic  closes_abc;
    word_t word;
  } dir_row_t;

  // One digest word as it should leave the block.
  typedef struct packed {
    word_t     word;
    hash_idx_t pos;
    logic      last;
  } digest_item_t;

  typedef enum logic [2:0] {
    BLK_RANDOM,
    BLK_ZERO,
    BLK_ONES,
    BLK_SPARSE,
    BLK_PADDED
  } block_kind_e;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_BURSTY
  } ready_mode_e;

  // Directed stimulus. The first sixteen rows are the padded one-block message "abc", whose
  // digest is the published test vector typed in below. The last nine rows put the field
  // extremes and alternating patterns at the head of the next block; the random part then
  // completes that block, and its digest comes from the predictor.
  localparam dir_row_t DirTable [DirRows] = '{
    {1'b0, 32'h61626380}, {1'b0, 32'h00000000}, {1'b0, 32'h00000000}, {1'b0, 32'h00000000},
    {1'b0, 32'h00000000}, {1'b0, 32'h00000000}, {1'b0, 32'h00000000}, {1'b0, 32'h00000000},
    {1'b0, 32'h00000000}, {1'b0, 32'h00000000}, {1'b0, 32'h00000000}, {1'b0, 32'h00000000},
    {1'b0, 32'h00000000}, {1'b0, 32'h00000000}, {1'b0, 32'h00000000}, {1'b1, 32'h00000018},
    {1'b0, 32'h00000000}, {1'b0, 32'hffffffff}, {1'b0, 32'h80000000}, {1'b0, 32'h00000001},
    {1'b0, 32'h7fffffff}, {1'b0, 32'hfffffffe}, {1'b0, 32'h55555555}, {1'b0, 32'haaaaaaaa},
    {1'b0, 32'h0000ffff}
  };

  localparam word_t AbcDigest [NumHash] = '{
    32'hba7816bf, 32'h8f01cfea, 32'h414140de, 32'h5dae2223,
    32'hb00361a3, 32'h96177a9c, 32'hb410ff61, 32'hf20015ad
  };

  // Standard starting hash and round constants, held here independently of the RTL.
  localparam word_t StartHash [NumHash] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundConst [NumRnd] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic clk_i;
  logic rst_ni;

  sha256bc_msg_if msg_if ();
  sha256bc_dig_if dig_if ();

  sha256_block_compression_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if.sink),
    .dig_o  (dig_if.source)
  );

  // Predictor state: the words of the block being gathered and how many are held.
  word_t        gathered_words [NumMsg];
  logic [3:0]   gathered_count;
  digest_item_t pending_digest_q [$];

  // Sender and receiver bookkeeping.
  word_t       next_block [NumMsg];
  int          burst_left;
  int          words_sent;
  int          blocks_started;
  ready_mode_e ready_mode;
  int          ready_left;
  int          idle_cycles;
  int          error_count;

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------
  // Digest model
  // ---------------------------------------------------------------------------------------

  function automatic word_t ror32(input word_t v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // Compress the gathered block from the starting hash and queue its eight digest words.
  // For the known block, queue the published digest instead.
  task automatic queue_block_digest(input logic use_abc);
    word_t        sched [NumRnd];
    word_t        hv [NumHash];
    word_t        a, b, c, d, e, f, g, h, t1, t2;
    digest_item_t item;
    for (int t = 0; t < NumMsg; t++) sched[t] = gathered_words[t];
    for (int t = NumMsg; t < NumRnd; t++) begin
      sched[t] = (ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10))
               + sched[t-7]
               + (ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3))
               + sched[t-16];
    end
    {a, b, c, d, e, f, g, h} = {StartHash[0], StartHash[1], StartHash[2], StartHash[3],
                                StartHash[4], StartHash[5], StartHash[6], StartHash[7]};
    for (int t = 0; t < NumRnd; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + RoundConst[t] + sched[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    hv[0] = StartHash[0] + a;
    hv[1] = StartHash[1] + b;
    hv[2] = StartHash[2] + c;
    hv[3] = StartHash[3] + d;
    hv[4] = StartHash[4] + e;
    hv[5] = StartHash[5] + f;
    hv[6] = StartHash[6] + g;
    hv[7] = StartHash[7] + h;
    for (int k = 0; k < NumHash; k++) begin
      item.word = use_abc ? AbcDigest[k] : hv[k];
      item.pos  = hash_idx_t'(k);
      item.last = (k == NumHash - 1);
      pending_digest_q.push_back(item);
    end
  endtask

  // Store an accepted word; on the sixteenth the count wraps and the digest is due.
  task automatic absorb_word(input word_t w, input logic use_abc);
    gathered_words[gathered_count] = w;
    gathered_count = gathered_count + 4'd1;
    if (gathered_count == 4'd0) queue_block_digest(use_abc);
  endtask

  // ---------------------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------------------

  // Called and left at a falling edge. Words go in bursts of random length; between bursts
  // drop valid for a random gap, or carry straight on so that bursts run together.
  task automatic drive_word(input word_t w, input logic use_abc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        msg_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
    end
    msg_if.valid        <= 1'b1;
    msg_if.message_word <= w;
    // Valid is high from here on, so the transaction completes on the first edge with ready.
    do @(posedge clk_i); while (!msg_if.ready);
    absorb_word(w, use_abc);
    words_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // Hold the sender off until every queued digest word has come out. Called at a falling
  // edge and returns at one.
  task automatic drain_digests();
    msg_if.valid <= 1'b0;
    while (pending_digest_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Fill next_block with sixteen words of the requested flavour.
  task automatic build_block(input block_kind_e kind);
    int unsigned len;
    int unsigned r;
    logic [7:0]  byte_val;
    for (int i = 0; i < NumMsg; i++) begin
      r = $urandom_range(0, 31);
      case (kind)
        BLK_ZERO: next_block[i] = '0;
        BLK_ONES: next_block[i] = '1;
        BLK_SPARSE: begin
          case ($urandom_range(0, 3))
            0:       next_block[i] = word_t'(1) << r;
            1:       next_block[i] = ~(word_t'(1) << r);
            2:       next_block[i] = '0;
            default: next_block[i] = '1;
          endcase
        end
        default: next_block[i] = $urandom;
      endcase
    end
    // A well-formed one-block message: random bytes, the 0x80 marker, zero fill and the
    // bit length in the last two words.
    if (kind == BLK_PADDED) begin
      len = $urandom_range(0, 55);
      for (int i = 0; i < NumMsg; i++) next_block[i] = '0;
      for (int bi = 0; bi < 56; bi++) begin
        if (bi < len)       byte_val = 8'($urandom_range(0, 255));
        else if (bi == len) byte_val = 8'h80;
        else                byte_val = 8'h00;
        next_block[bi / 4][31 - 8 * (bi % 4) -: 8] = byte_val;
      end
      next_block[15] = word_t'(len * 8);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver: ready follows a pattern of its own, redrawn at random after each run of it
  // ---------------------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (ready_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 3));
        ready_left = $urandom_range(4, 48);
      end
      ready_left--;
      case (ready_mode)
        RDY_ALWAYS: dig_if.ready <= 1'b1;
        RDY_COIN:   dig_if.ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: dig_if.ready <= ($urandom_range(0, 3) == 0);
        default:    dig_if.ready <= ready_left[2];
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("ERROR at %0t ns: %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Compare every digest transaction, field by field, against the oldest pending word.
  always @(posedge clk_i) begin
    digest_item_t want;
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      if (pending_digest_q.size() == 0) begin
        report_mismatch("digest word with nothing pending", dig_if.digest_word, '0);
      end else begin
        want = pending_digest_q.pop_front();
        if (dig_if.digest_word !== want.word)
          report_mismatch("digest_word", dig_if.digest_word, want.word);
        if (dig_if.digest_index !== want.pos)
          report_mismatch("digest_index", word_t'(dig_if.digest_index), word_t'(want.pos));
        if (dig_if.last_word !== want.last)
          report_mismatch("last_word", word_t'(dig_if.last_word), word_t'(want.last));
      end
    end
  end

  // Watchdog: abandon the run when neither channel has moved a transaction for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (msg_if.valid && msg_if.ready) || (dig_if.valid && dig_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no transaction for %0d cycles", IdleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    block_kind_e kind;
    int unsigned pick;
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    msg_if.valid        = 1'b0;
    msg_if.message_word = '0;
    dig_if.ready        = 1'b0;
    gathered_count      = '0;
    burst_left          = 0;
    words_sent          = 0;
    blocks_started      = 0;
    ready_left          = 0;
    ready_mode          = RDY_ALWAYS;
    idle_cycles         = 0;
    error_count         = 0;

    // Hold reset, then release it away from the rising edge.
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table.
    for (int i = 0; i < DirRows; i++) drive_word(DirTable[i].word, DirTable[i].closes_abc);

    // Random part: complete the open block, then whole blocks of mixed flavours until
    // the word budget is spent on a block boundary.
    build_block(BLK_RANDOM);
    while (words_sent < ItemsTarget || gathered_count != 4'd0) begin
      if (gathered_count == 4'd0) begin
        blocks_started++;
        // Pause now and then until the block has returned every digest word.
        if (blocks_started == 2 || $urandom_range(0, 9) == 0) drain_digests();
        pick = $urandom_range(0, 9);
        case (pick)
          0:       kind = BLK_ZERO;
          1:       kind = BLK_ONES;
          2:       kind = BLK_SPARSE;
          3, 4, 5: kind = BLK_PADDED;
          default: kind = BLK_RANDOM;
        endcase
        build_block(kind);
      end
      drive_word(next_block[gathered_count], 1'b0);
    end

    // Drop valid, let the last digests come out, then watch for anything stray.
    drain_digests();
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
